// ----- rtl/core/energy_voice_activity_detector_top_macros.svh -----
// ----------------------------------------------------------------------------
// Energy VAD assertion macros
// Shorthand for the clocked, reset-gated properties used by the checker.
// Each macro expects signals named clk and rst in the calling scope.
// ----------------------------------------------------------------------------
`ifndef ENERGY_VOICE_ACTIVITY_DETECTOR_TOP_MACROS_SVH
`define ENERGY_VOICE_ACTIVITY_DETECTOR_TOP_MACROS_SVH

// same-cycle implication
`define EVAD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EVAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/evad_pkg.sv -----
// ----------------------------------------------------------------------------
// Energy VAD package
// Widths, register indexes and fixed constants shared by the detector files.
// ----------------------------------------------------------------------------
`default_nettype none

package evad_pkg;

  localparam int MAX_CHUNK  = 4096;

  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 16;
  localparam int SQ_W       = 2 * MAG_W - 1;            // 32768^2 = 2^30
  localparam int CNT_W      = $clog2(MAX_CHUNK + 1);
  localparam int SUM_W      = SQ_W + $clog2(MAX_CHUNK);

  localparam int ROOT_W     = 16;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 1;
  localparam int ALU_W      = REM_W + 2;
  localparam int STEP_W     = $clog2(SUM_W);

  localparam int FRAC_W     = 8;
  localparam int LEVEL_W    = ROOT_W + FRAC_W;
  localparam int OUT_LVL_W  = 16;

  localparam int ALPHA_FRAC = 16;
  localparam int ALPHA_W    = ALPHA_FRAC + 1;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_FRAC);
  localparam int PROD_W     = ALPHA_W + LEVEL_W;

  localparam int THR_W      = 16;
  localparam int HOLD_W     = 10;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ALPHA_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD     = 2'd0,
    REG_HOLD_FRAMES   = 2'd1,
    REG_ALPHA_ATTACK  = 2'd2,
    REG_ALPHA_RELEASE = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

// ----- rtl/core/evad_if.sv -----
// ----------------------------------------------------------------------------
// Energy VAD channels
// Sample input, result output and register write channels (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface evad_in_if;
  import evad_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  modport source  (output valid, op, sample, last, input ready);
  modport sink    (input valid, op, sample, last, output ready);
  modport monitor (input valid, ready, op, sample, last);
endinterface

interface evad_out_if;
  import evad_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 voice;
  logic [OUT_LVL_W-1:0] level;
  modport source  (output valid, voice, level, input ready);
  modport sink    (input valid, voice, level, output ready);
  modport monitor (input valid, ready, voice, level);
endinterface

interface evad_cfg_if;
  import evad_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source  (output valid, index, data, input ready);
  modport sink    (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface

`default_nettype wire

// ----- rtl/core/energy_voice_activity_detector_top.sv -----
// A plain audio sample is accepted in S_IDLE, then makes one pass through the
// shared multiplier in S_SQUARE to square it into the chunk sum. The sample that
// closes a chunk (last set, or the 4096th sample) then runs the bit-serial mean
// division and the bit-pair square root (both run on one shared subtractor),
// the smoothing update on the shared multiplier (S_MUL_A, S_MUL_B) and S_EMIT
// to post the result, plus any wait while the previous result word is still
// held in the output register. A clear word is done in its accept cycle.
// Register writes are taken in any cycle out of reset.
// ----------------------------------------------------------------------------
// Energy voice activity detector
// Chunk rms by sum of squares, divide and square root, asymmetric smoothing,
// threshold with hangover; one voice/level word per chunk.
// ----------------------------------------------------------------------------
`default_nettype none

module energy_voice_activity_detector_top (
  input  logic          clk,
  input  logic          rst,
  evad_in_if.sink       samples,
  evad_out_if.source    results,
  evad_cfg_if.sink      cfg
);
  import evad_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SQUARE = 7'b0000010,
    S_DIVIDE = 7'b0000100,
    S_SQRT   = 7'b0001000,
    S_MUL_A  = 7'b0010000,
    S_MUL_B  = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [THR_W-1:0]     threshold;
  logic [HOLD_W-1:0]    hold_frames;
  logic [ALPHA_W-1:0]   alpha_attack;
  logic [ALPHA_W-1:0]   alpha_release;

  logic [SUM_W-1:0]     square_sum;
  logic [CNT_W-1:0]     sample_count;
  logic [LEVEL_W-1:0]   smoothed_level;
  logic [HOLD_W-1:0]    hold_left;
  logic                 voice_flag;

  logic [MAG_W-1:0]     mag;
  logic                 last_q;
  logic [REM_W-1:0]     rem;
  logic [ROOT_W-1:0]    root;
  logic [PROD_W-1:0]    acc;
  logic [STEP_W-1:0]    step;

  logic                 out_valid;
  logic                 out_voice;
  logic [OUT_LVL_W-1:0] out_level;

  logic [SAMPLE_W-1:0]  sample_u;
  logic                 in_fire;
  logic [CNT_W-1:0]     count_inc;
  logic                 chunk_close;
  logic [SUM_W-1:0]     sum_add;
  logic [LEVEL_W-1:0]   rms_level;
  logic [ALPHA_W-1:0]   a_raw;
  logic [ALPHA_W-1:0]   a_sel;
  logic [ALPHA_W-1:0]   a_comp;
  logic [ALPHA_W-1:0]   mul_a;
  logic [LEVEL_W-1:0]   mul_b;
  logic [PROD_W-1:0]    prod;
  logic [PROD_W-1:0]    ema_sum;
  logic [ALU_W-1:0]     alu_a;
  logic [ALU_W-1:0]     alu_b;
  logic [ALU_W:0]       alu_diff;
  logic                 alu_ge;
  logic [HOLD_W-1:0]    hold_load;
  logic                 above;
  logic                 voice_new;
  logic [HOLD_W-1:0]    hold_new;
  logic                 out_free;

  assign sample_u    = $unsigned(samples.sample);
  assign in_fire     = samples.valid && samples.ready;
  assign count_inc   = sample_count + CNT_W'(1);
  assign chunk_close = last_q || (count_inc == CNT_W'(MAX_CHUNK));
  assign sum_add     = square_sum + SUM_W'(prod[SQ_W-1:0]);

  // smoothing factor: attack on a rising level, saturated at one
  assign rms_level = {root, FRAC_W'(0)};
  assign a_raw     = (rms_level > smoothed_level) ? alpha_attack : alpha_release;
  assign a_sel     = (a_raw > ALPHA_ONE) ? ALPHA_ONE : a_raw;
  assign a_comp    = ALPHA_ONE - a_sel;

  // shared multiplier
  always_comb begin
    unique case (state)
      S_SQUARE: begin
        mul_a = ALPHA_W'(mag);
        mul_b = LEVEL_W'(mag);
      end
      S_MUL_A: begin
        mul_a = a_sel;
        mul_b = rms_level;
      end
      S_MUL_B: begin
        mul_a = a_comp;
        mul_b = smoothed_level;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign ema_sum = acc + prod;

  // shared subtractor: restoring divide step, or bit-pair square root step
  always_comb begin
    unique case (state)
      S_DIVIDE: begin
        alu_a = ALU_W'({rem[CNT_W-1:0], square_sum[SUM_W-1]});
        alu_b = ALU_W'(sample_count);
      end
      S_SQRT: begin
        alu_a = {rem, square_sum[RAD_W-1 -: 2]};
        alu_b = ALU_W'({root, 2'b01});
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = !alu_diff[ALU_W];

  // voice decision with hangover; a zero hold still holds one chunk
  assign hold_load = (hold_frames == '0) ? HOLD_W'(1) : hold_frames;
  assign above     = smoothed_level >= {threshold, FRAC_W'(0)};

  always_comb begin
    if (above) begin
      voice_new = 1'b1;
      hold_new  = hold_load;
    end else if (hold_left != '0) begin
      voice_new = 1'b1;
      hold_new  = hold_left - HOLD_W'(1);
    end else begin
      voice_new = 1'b0;
      hold_new  = hold_left;
    end
  end

  assign out_free = !out_valid || results.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_fire && !samples.op) state_next = S_SQUARE;
      S_SQUARE: state_next = chunk_close ? S_DIVIDE : S_IDLE;
      S_DIVIDE: if (step == '0) state_next = S_SQRT;
      S_SQRT:   if (step == '0) state_next = S_MUL_A;
      S_MUL_A:  state_next = S_MUL_B;
      S_MUL_B:  state_next = S_EMIT;
      S_EMIT:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      threshold      <= THR_W'(655);
      hold_frames    <= HOLD_W'(10);
      alpha_attack   <= ALPHA_W'(39322);
      alpha_release  <= ALPHA_W'(3277);
      square_sum     <= '0;
      sample_count   <= '0;
      smoothed_level <= '0;
      hold_left      <= '0;
      voice_flag     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_THRESHOLD:     threshold     <= cfg.data[THR_W-1:0];
          REG_HOLD_FRAMES:   hold_frames   <= cfg.data[HOLD_W-1:0];
          REG_ALPHA_ATTACK:  alpha_attack  <= cfg.data[ALPHA_W-1:0];
          REG_ALPHA_RELEASE: alpha_release <= cfg.data[ALPHA_W-1:0];
          default: ;
        endcase
      end

      if (state == S_EMIT && out_free) out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (samples.op) begin
              square_sum     <= '0;
              sample_count   <= '0;
              smoothed_level <= '0;
              hold_left      <= '0;
              voice_flag     <= 1'b0;
            end else begin
              mag    <= sample_u[SAMPLE_W-1] ? (~sample_u + MAG_W'(1)) : sample_u;
              last_q <= samples.last;
            end
          end
        end
        S_SQUARE: begin
          square_sum   <= sum_add;
          sample_count <= count_inc;
          rem          <= '0;
          step         <= STEP_W'(SUM_W - 1);
        end
        S_DIVIDE: begin
          // quotient bits shift in behind the dividend
          square_sum <= {square_sum[SUM_W-2:0], alu_ge};
          if (step == '0) begin
            rem  <= '0;
            root <= '0;
            step <= STEP_W'(ROOT_W - 1);
          end else begin
            rem  <= alu_ge ? alu_diff[REM_W-1:0] : alu_a[REM_W-1:0];
            step <= step - STEP_W'(1);
          end
        end
        S_SQRT: begin
          rem        <= alu_ge ? alu_diff[REM_W-1:0] : alu_a[REM_W-1:0];
          root       <= {root[ROOT_W-2:0], alu_ge};
          square_sum <= square_sum << 2;
          step       <= step - STEP_W'(1);
        end
        S_MUL_A: begin
          acc <= prod;
        end
        S_MUL_B: begin
          smoothed_level <= ema_sum[ALPHA_FRAC +: LEVEL_W];
        end
        S_EMIT: begin
          if (out_free) begin
            voice_flag   <= voice_new;
            hold_left    <= hold_new;
            out_voice    <= voice_new;
            out_level    <= smoothed_level[FRAC_W +: OUT_LVL_W];
            square_sum   <= '0;
            sample_count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign samples.ready = (state == S_IDLE) && !rst;
  assign cfg.ready     = !rst;
  assign results.valid = out_valid;
  assign results.voice = out_voice;
  assign results.level = out_level;

endmodule

`default_nettype wire

// ----- rtl/core/evad_checker.sv -----
// ----------------------------------------------------------------------------
// Energy VAD port checker
// Watches the detector's channels and flags sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "energy_voice_activity_detector_top_macros.svh"

module evad_checker (
  input  logic          clk,
  input  logic          rst,
  evad_in_if.sink       samples,
  evad_out_if.source    results,
  evad_cfg_if.sink      cfg
);
  import evad_pkg::*;

  // an accepted sample word always leaves the detector busy
  `EVAD_ASSERT_NEXT(a_sample_busy, samples.valid && samples.ready && !samples.op, !samples.ready, "sample accepted back to back")

  // a clear word finishes in its own cycle
  `EVAD_ASSERT_NEXT(a_clear_quick, samples.valid && samples.ready && samples.op, samples.ready, "clear left the detector busy")

  `EVAD_ASSERT_NEXT(a_out_hold, results.valid && !results.ready, results.valid && $stable(results.level) && $stable(results.voice), "stalled result word changed")

  // smoothed level never exceeds full scale
  `EVAD_ASSERT_IMPL(a_level_range, results.valid, results.level <= 16'h8000, "level above full scale")

  `EVAD_ASSERT_IMPL(a_cfg_open, cfg.valid, cfg.ready, "register write stalled")

endmodule

bind energy_voice_activity_detector_top evad_checker u_evad_checker (
  .clk     (clk),
  .rst     (rst),
  .samples (samples),
  .results (results),
  .cfg     (cfg)
);

`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Energy voice activity detector testbench
// Drives audio words, clears and register writes through the valid/ready
// channels, predicts every voice/level word in a scoreboard and compares the
// words that come back, under several handshake idling modes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import evad_pkg::*;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;
  localparam int   SETTLE    = 80;     // cycles past the last word, covers a chunk close
  localparam int   REPORT_MAX = 10;

  typedef struct {
    logic                 voice;
    logic [OUT_LVL_W-1:0] level;
  } vad_word_t;

  // --------------------------------------------------------------------------
  class vad_scoreboard;
    logic [THR_W-1:0]   thr;
    logic [HOLD_W-1:0]  hold_cfg;
    logic [ALPHA_W-1:0] a_att;
    logic [ALPHA_W-1:0] a_rel;

    longint unsigned    sq_sum;
    int                 n_samp;
    logic [LEVEL_W-1:0] ema;
    logic [HOLD_W-1:0]  hang;
    logic               voice_q;

    vad_word_t pending[$];
    int words, chunks, full_chunks, clears, checked, errors, cfg_writes;

    function new();
      thr      = 16'd655;
      hold_cfg = 10'd10;
      a_att    = 17'd39322;
      a_rel    = 17'd3277;
      clear_state();
    endfunction

    function void clear_state();
      sq_sum  = 0;
      n_samp  = 0;
      ema     = '0;
      hang    = '0;
      voice_q = 1'b0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      cfg_writes++;
      case (idx)
        REG_THRESHOLD:     thr      = v[THR_W-1:0];
        REG_HOLD_FRAMES:   hold_cfg = v[HOLD_W-1:0];
        REG_ALPHA_ATTACK:  a_att    = v;
        REG_ALPHA_RELEASE: a_rel    = v;
        default: ;
      endcase
    endfunction

    // bit-by-bit trial root, floor of the square root
    function logic [ROOT_W-1:0] floor_root(longint unsigned v);
      longint unsigned root, trial;
      root = 0;
      for (int i = ROOT_W - 1; i >= 0; i--) begin
        trial = root | (longint'(1) << i);
        if (trial * trial <= v) root = trial;
      end
      return root[ROOT_W-1:0];
    endfunction

    function void note_word(logic op, logic [SAMPLE_W-1:0] raw, logic last);
      longint unsigned mag, mean, r, e, a, nxt;
      logic [HOLD_W-1:0] hold_eff;
      vad_word_t w;
      words++;
      if (op == OP_CLEAR) begin
        clears++;
        clear_state();
        return;
      end
      mag = raw[SAMPLE_W-1] ? (longint'(1) << SAMPLE_W) - raw : raw;
      sq_sum += mag * mag;
      n_samp++;
      if (!last && n_samp < MAX_CHUNK) return;

      if (!last) full_chunks++;
      chunks++;
      mean = sq_sum / n_samp;
      r = longint'(floor_root(mean)) << FRAC_W;
      e = ema;
      a = (r > e) ? a_att : a_rel;
      if (a > ALPHA_ONE) a = ALPHA_ONE;
      nxt = (a * r + (longint'(ALPHA_ONE) - a) * e) >> ALPHA_FRAC;
      ema = nxt[LEVEL_W-1:0];

      hold_eff = (hold_cfg == 0) ? 10'd1 : hold_cfg;
      if (ema >= (longint'(thr) << FRAC_W)) begin
        hang    = hold_eff;
        voice_q = 1'b1;
      end else if (hang != 0) begin
        hang    = hang - 1'b1;
        voice_q = 1'b1;
      end else begin
        voice_q = 1'b0;
      end
      sq_sum = 0;
      n_samp = 0;

      w.voice = voice_q;
      w.level = ema[LEVEL_W-1 -: OUT_LVL_W];
      pending.push_back(w);
    endfunction

    function void check_word(logic voice, logic [OUT_LVL_W-1:0] level);
      vad_word_t w;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: unexpected word voice=%0b level=%0d", $realtime, voice, level);
        return;
      end
      w = pending.pop_front();
      if (voice !== w.voice || level !== w.level) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: word %0d mismatch: voice exp %0b got %0b, level exp %0d got %0d",
                   $realtime, checked, w.voice, voice, w.level, level);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  evad_in_if  in_ch ();
  evad_out_if out_ch ();
  evad_cfg_if cfg_ch ();

  energy_voice_activity_detector_top dut (
    .clk     (clk),
    .rst     (rst),
    .samples (in_ch),
    .results (out_ch),
    .cfg     (cfg_ch)
  );

  vad_scoreboard sb = new();

  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_off_len    = 0;
  int hold_off_ticket = 0;
  int ticket_seen     = 0;
  int hold_off_cnt    = 0;
  int settings_used   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_off_ticket != ticket_seen) begin
      ticket_seen  <= hold_off_ticket;
      hold_off_cnt <= hold_off_len;
      out_ch.ready <= 1'b0;
    end else if (hold_off_cnt != 0) begin
      hold_off_cnt <= hold_off_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_word(in_ch.op, in_ch.sample, in_ch.last);
      if (out_ch.valid && out_ch.ready)
        sb.check_word(out_ch.voice, out_ch.level);
    end
  end

  // --------------------------------------------------------------------------
  task automatic send_word(logic op, logic [SAMPLE_W-1:0] smp, logic lst);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.sample <= smp;
    in_ch.last   <= lst;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop sending and wait until every predicted word is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_regs(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] hold,
                           logic [CFG_DATA_W-1:0] att, logic [CFG_DATA_W-1:0] rel);
    logic [CFG_DATA_W-1:0] vals[4];
    vals = '{thr, hold, att, rel};
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= cfg_reg_t'(i);
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
      sb.write_reg(cfg_reg_t'(i), vals[i]);
    end
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(int amp_bits);
    logic [SAMPLE_W-1:0] v;
    if (amp_bits >= SAMPLE_W) return SAMPLE_W'($urandom);
    v = SAMPLE_W'($urandom_range((1 << amp_bits) - 1, 0));
    return $urandom_range(1) ? -v : v;
  endfunction

  // chunks of random length and loudness; loudness drifts so that the
  // level rises and decays across several chunks
  task automatic run_chunks(int target);
    int sent, len, amp, pick;
    logic lst;
    sent = 0;
    amp  = $urandom_range(SAMPLE_W);
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 70)      len = $urandom_range(4, 1);
      else if (pick < 90) len = $urandom_range(16, 5);
      else if (pick < 99) len = $urandom_range(80, 17);
      else                len = $urandom_range(500, 200);
      if ($urandom_range(99) < 25) amp = $urandom_range(SAMPLE_W);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 2) begin
          send_word(OP_CLEAR, SAMPLE_W'($urandom), 1'($urandom_range(1)));
          sent++;
        end
        // occasionally the last flag is lost and the chunk runs on
        lst = (i == len - 1) && ($urandom_range(99) >= 3);
        if ($urandom_range(99) < 3)
          send_word(OP_SAMPLE, $urandom_range(1) ? 16'h8000 : 16'h7fff, lst);
        else
          send_word(OP_SAMPLE, pick_sample(amp), lst);
        sent++;
      end
    end
  endtask

  task automatic set_mode(int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct <= 0;  end
      1: begin idle_pct = 63; stall_pct <= 0;  end
      2: begin idle_pct = 0;  stall_pct <= 63; end
      default: begin idle_pct = 16; stall_pct <= 16; end
    endcase
  endtask

  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_SAMPLE;
    in_ch.sample = '0;
    in_ch.last   = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_THRESHOLD;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset values written back explicitly
    load_regs(17'd655, 17'd10, 17'd39322, 17'd3277);
    send_word(OP_SAMPLE, 16'h7fff, 1'b1);
    send_word(OP_SAMPLE, 16'h8000, 1'b1);     // magnitude 32768
    send_word(OP_SAMPLE, 16'h0000, 1'b1);     // falls, release path
    send_word(OP_SAMPLE, 16'h0001, 1'b0);
    send_word(OP_SAMPLE, 16'hffff, 1'b0);
    send_word(OP_SAMPLE, 16'h4000, 1'b1);
    send_word(OP_CLEAR, 16'h7fff, 1'b1);      // clear carries no word out
    send_word(OP_SAMPLE, 16'h0000, 1'b1);
    send_word(OP_SAMPLE, 16'h8000, 1'b0);
    send_word(OP_SAMPLE, 16'd12345, 1'b0);
    send_word(OP_CLEAR, 16'hffff, 1'b0);      // clear in the middle of a chunk
    send_word(OP_SAMPLE, 16'd100, 1'b1);
    send_word(OP_SAMPLE, 16'd5000, 1'b1);
    send_word(OP_SAMPLE, 16'd0, 1'b1);        // hangover counts down
    send_word(OP_SAMPLE, 16'd0, 1'b1);
    drain();
    // zero threshold and hold, attack above one saturates
    load_regs(17'd0, 17'd0, 17'h1ffff, 17'd0);
    send_word(OP_SAMPLE, 16'h8000, 1'b1);
    send_word(OP_SAMPLE, 16'h8000, 1'b1);     // rms equal to level
    send_word(OP_SAMPLE, 16'd0, 1'b1);
    drain();
    load_regs(17'd32768, 17'd1023, 17'd65536, 17'd65537);
    send_word(OP_SAMPLE, 16'h8000, 1'b1);     // level reaches 32768
    send_word(OP_SAMPLE, 16'd0, 1'b1);
    drain();
    load_regs(17'h1ffff, 17'h1ffff, 17'd30000, 17'd1000);
    // chunk closed by length alone
    for (int i = 0; i < MAX_CHUNK; i++) send_word(OP_SAMPLE, SAMPLE_W'($urandom), 1'b0);
    send_word(OP_SAMPLE, 16'd777, 1'b1);
    drain();

    // random part: one register setting and one idling mode per phase
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_regs(17'd655, 17'd10, 17'd39322, 17'd3277);
        1: load_regs(17'd0, 17'd0, 17'd0, 17'd0);
        2: load_regs(17'd32768, 17'd1023, 17'd65536, 17'd65536);
        3: load_regs(17'($urandom_range(4000)), 17'($urandom_range(12, 1)),
                     17'h1ffff, 17'd65537);
        4, 5: load_regs(17'($urandom_range(6000)), 17'($urandom_range(20, 1)),
                        17'($urandom_range(65536)), 17'($urandom_range(65536)));
        6: load_regs(17'($urandom_range(2000)), 17'($urandom_range(1023)),
                     17'($urandom_range(65536, 20000)), 17'($urandom_range(8000)));
        default: load_regs(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
      endcase
      set_mode(ph % 4);
      run_chunks(135);
      drain();

      if (ph == 3) begin
        // receiver holds off while short chunks keep coming: the block backs up
        set_mode(0);
        @(posedge clk);
        hold_off_len    <= 2000;
        hold_off_ticket <= hold_off_ticket + 1;
        for (int i = 0; i < 120; i++)
          send_word(OP_SAMPLE, pick_sample($urandom_range(SAMPLE_W)), i[0]);
        drain();
      end
    end

    set_mode(0);
    drain();

    $display("covered %0d words: %0d chunks (%0d closed by length), %0d clears",
             sb.words, sb.chunks, sb.full_chunks, sb.clears);
    $display("%0d register settings, %0d words checked, %0d mismatches, %0d missing",
             settings_used, sb.checked, sb.errors, sb.pending.size());
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("timeout with %0d words outstanding", sb.pending.size());
    $display("tb: failure");
    $finish;
  end

endmodule
